### design/nibble_framebuffer_engine_top_defines.svh
// Assertion macros shared by the frame buffer engine RTL.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef NIBBLE_FRAMEBUFFER_ENGINE_TOP_DEFINES_SVH
`define NIBBLE_FRAMEBUFFER_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NFB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NFB_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nfb_pkg.sv
// Shared types, constants and sizes of the nibble frame buffer engine.
// Used by every module of the block but nfb_ram; depends on nothing.
package nfb_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 64;
  localparam int PIXEL_BITS  = 4;
  localparam int MAX_STRIDE  = (MAX_WIDTH * PIXEL_BITS + 7) / 8;
  localparam int STORE_DEPTH = MAX_STRIDE * MAX_HEIGHT;

  // Derived widths
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int SIZE_W   = $clog2(STORE_DEPTH + 1);
  localparam int STRIDE_W = $clog2(MAX_STRIDE + 1);

  // Register widths and configuration port
  localparam int WIDTH_W   = 9;
  localparam int HEIGHT_W  = 7;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;

  // Request codes
  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Nibble masks
  localparam logic [7:0] MASK_LO = 8'h0F;
  localparam logic [7:0] MASK_HI = 8'hF0;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [3:0]         color;
  } in_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_rsp_t;

  // Decoded geometry of the current frame and request
  typedef struct packed {
    logic              draw_hit;
    logic [ADDR_W-1:0] draw_addr;
    logic              odd;
    logic [SIZE_W-1:0] frame_size;
  } geom_t;

  // One write into the frame store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef enum logic [1:0] {
    SW_IDLE = 2'b01,
    SW_FILL = 2'b10
  } sweep_state_t;

endpackage

### design/nibble_framebuffer_engine_top.sv
// Top level of the nibble frame buffer engine: config registers, request
// pipeline, read pointer and output register. Depends on nfb_pkg, nfb_ram,
// nfb_geom, nfb_sweep and the assertion macro header.
// Draw and read take one request per cycle while no fill or stall holds them off;
// a read result goes from the store read register and second stage into the output
// register, and holds off requests while stalled. A clear holds off requests while
// it writes the frame, one byte per cycle through the single write port of the store.
// Reset clears the whole store with a zero pass before the first request.
`include "nibble_framebuffer_engine_top_defines.svh"

module nibble_framebuffer_engine_top
  import nfb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_rsp_t             out_rsp
);

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  geom_t               geom;

  logic                accept;
  logic                is_draw;
  logic                is_read;
  logic                is_clear;
  logic                stall;
  logic                sweep_busy;
  wr_t                 sweep_wr;
  wr_t                 draw_wr;

  logic [ADDR_W-1:0]   read_pointer;
  logic [ADDR_W-1:0]   rd_p;
  logic [SIZE_W-1:0]   rd_p_inc;
  logic                rd_last;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          rd_data;

  logic                b_valid;
  logic                b_read;
  logic [ADDR_W-1:0]   b_addr;
  logic                b_odd;
  logic [3:0]          b_color;
  logic                b_last;
  logic [7:0]          cur_byte;

  logic                fwd_valid;
  logic [ADDR_W-1:0]   fwd_addr;
  logic [7:0]          fwd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  nfb_geom u_geom (
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .req          (in_req),
    .geom         (geom)
  );

  // Request decode
  assign stall    = b_valid && b_read && out_valid && !out_ready;
  assign in_ready = !sweep_busy && !stall;
  assign accept   = in_valid && in_ready;
  assign is_draw  = accept && (in_req.req_type == REQ_DRAW) && geom.draw_hit;
  assign is_read  = accept && (in_req.req_type == REQ_READ);
  assign is_clear = accept && (in_req.req_type == REQ_CLEAR);

  // Read pointer: restart at zero when outside the frame, wrap after the last byte
  assign rd_p     = ({1'b0, read_pointer} >= SIZE_W'(geom.frame_size)) ? '0 : read_pointer;
  assign rd_p_inc = SIZE_W'(rd_p) + SIZE_W'(1);
  assign rd_last  = (rd_p_inc >= geom.frame_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer <= '0;
    end else if (is_read) begin
      read_pointer <= rd_last ? '0 : rd_p_inc[ADDR_W-1:0];
    end
  end

  nfb_sweep u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (is_clear),
    .fill      ({in_req.color, in_req.color}),
    .last_addr (ADDR_W'(geom.frame_size - SIZE_W'(1))),
    .busy      (sweep_busy),
    .wr        (sweep_wr)
  );

  // Frame store port selection
  assign ram_re    = is_draw || is_read;
  assign ram_raddr = is_read ? rd_p : geom.draw_addr;
  assign ram_we    = draw_wr.we || sweep_wr.we;
  assign ram_waddr = sweep_wr.we ? sweep_wr.addr : draw_wr.addr;
  assign ram_wdata = sweep_wr.we ? sweep_wr.data : draw_wr.data;

  nfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Second stage: hold while a read result cannot leave
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!stall) begin
      b_valid <= is_draw || is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      b_read  <= is_read;
      b_addr  <= ram_raddr;
      b_odd   <= geom.odd;
      b_color <= in_req.color;
      b_last  <= rd_last;
    end
  end

  // Forward the last draw write over the stale read data
  assign cur_byte = (fwd_valid && fwd_addr == b_addr) ? fwd_data : rd_data;

  // Modify one nibble of the byte
  assign draw_wr.we   = b_valid && !b_read;
  assign draw_wr.addr = b_addr;
  assign draw_wr.data = b_odd ? ((cur_byte & MASK_HI) | {4'h0, b_color})
                              : ((cur_byte & MASK_LO) | {b_color, 4'h0});

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (!stall) begin
      fwd_valid <= draw_wr.we;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      fwd_addr <= draw_wr.addr;
      fwd_data <= draw_wr.data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_valid && b_read && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_read && !stall) begin
      out_rsp.frame_byte <= cur_byte;
      out_rsp.last_byte  <= b_last;
    end
  end

  `NFB_ASSERT_IMP(a_port_excl, clk, rst, sweep_wr.we, !draw_wr.we, "fill and draw write collide")
  `NFB_ASSERT_IMP(a_fill_blocks, clk, rst, sweep_busy, !in_ready, "request taken during fill")
  `NFB_ASSERT_NEXT(a_stall_holds, clk, rst, stall, $stable(rd_data), "read data lost in stall")
  `NFB_ASSERT_NEXT(a_read_lands, clk, rst, b_valid && b_read && !stall,
    out_valid && out_rsp.frame_byte == $past(cur_byte), "read result not delivered")

endmodule

### design/nfb_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module nfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/nfb_geom.sv
// Frame geometry: clamped size, row stride, frame bytes and draw address check.
// Depends on nfb_pkg.
module nfb_geom
  import nfb_pkg::*;
(
  input  logic [WIDTH_W-1:0]  frame_width,
  input  logic [HEIGHT_W-1:0] frame_height,
  input  in_req_t             req,
  output geom_t               geom
);

  localparam logic [WIDTH_W-1:0] WIDTH_LIM =
    WIDTH_W'((MAX_WIDTH > (1 << WIDTH_W) - 1) ? (1 << WIDTH_W) - 1 : MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIM =
    HEIGHT_W'((MAX_HEIGHT > (1 << HEIGHT_W) - 1) ? (1 << HEIGHT_W) - 1 : MAX_HEIGHT);
  localparam int PROD_W = STRIDE_W + HEIGHT_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [WIDTH_W:0]    w_round;
  logic [STRIDE_W-1:0] stride;
  logic [PROD_W-1:0]   size_prod;
  logic [15:0]         xu;
  logic [15:0]         yu;
  logic                in_frame;
  logic [SUM_W-1:0]    addr_full;

  // Clamp the registers to the legal frame
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (frame_width > WIDTH_LIM) begin
      eff_w = WIDTH_LIM;
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (frame_height > HEIGHT_LIM) begin
      eff_h = HEIGHT_LIM;
    end else begin
      eff_h = frame_height;
    end
  end

  // Two pixels per byte: stride is width halved, rounded up
  assign w_round   = {1'b0, eff_w} + (WIDTH_W + 1)'(1);
  assign stride    = w_round[STRIDE_W:1];
  assign size_prod = PROD_W'(stride) * PROD_W'(eff_h);

  // Limit the frame to the store
  assign geom.frame_size = (size_prod > PROD_W'(STORE_DEPTH)) ? SIZE_W'(STORE_DEPTH)
                                                              : size_prod[SIZE_W-1:0];

  // Bounds check on signed coordinates
  assign xu       = req.pixel_x;
  assign yu       = req.pixel_y;
  assign in_frame = !xu[15] && !yu[15] && (xu < 16'(eff_w)) && (yu < 16'(eff_h));

  // Byte address of the pixel
  assign addr_full = SUM_W'(SUM_W'(yu[HEIGHT_W-1:0]) * SUM_W'(stride))
                   + SUM_W'(xu[WIDTH_W-1:1]);

  assign geom.draw_hit  = in_frame && (addr_full < SUM_W'(STORE_DEPTH));
  assign geom.draw_addr = addr_full[ADDR_W-1:0];
  assign geom.odd       = xu[0];

endmodule

### design/nfb_sweep.sv
// Fill sequencer: writes one byte a cycle over a range of the frame store.
// Runs a full zero fill after reset. Depends on nfb_pkg.
module nfb_sweep
  import nfb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        fill,
  input  logic [ADDR_W-1:0] last_addr,
  output logic              busy,
  output wr_t               wr
);

  sweep_state_t      state;
  sweep_state_t      state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] end_addr;
  logic [7:0]        data;

  // Advance until the last byte is written
  always_comb begin
    state_next = state;
    unique case (state)
      SW_IDLE: begin
        if (start) begin
          state_next = SW_FILL;
        end
      end
      SW_FILL: begin
        if (cnt == end_addr) begin
          state_next = SW_IDLE;
        end
      end
      default: state_next = SW_IDLE;
    endcase
  end

  // Reset launches a zero fill of the whole store
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SW_FILL;
      cnt      <= '0;
      end_addr <= ADDR_W'(STORE_DEPTH - 1);
      data     <= '0;
    end else begin
      state <= state_next;
      if (state == SW_IDLE && start) begin
        cnt      <= '0;
        end_addr <= last_addr;
        data     <= fill;
      end else if (state == SW_FILL) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  assign busy    = (state == SW_FILL);
  assign wr.we   = (state == SW_FILL);
  assign wr.addr = cnt;
  assign wr.data = data;

endmodule

### verif/nibble_framebuffer_engine_top_test.sv
// Testbench for nibble_framebuffer_engine_top: draw, clear and read requests
// checked against a behavioral 4bpp frame store kept in the bench.
// Depends on nfb_pkg and the nibble_framebuffer_engine_top RTL.
module nibble_framebuffer_engine_top_test;
  import nfb_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 9;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_rsp_t             out_rsp;

  // Shadow frame store, read pointer and registers
  logic [7:0]          shadow_store [STORE_DEPTH];
  int unsigned         next_byte = 0;
  logic [WIDTH_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  out_rsp_t            expected_bytes [$];
  int                  errors = 0;
  bit                  gaps_on = 1'b1;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  nibble_framebuffer_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // Clamp the written geometry to the supported frame
  function automatic int unsigned vis_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned vis_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned row_bytes();
    return (vis_width() * PIXEL_BITS + 7) / 8;
  endfunction

  function automatic int unsigned frame_bytes();
    return row_bytes() * vis_height();
  endfunction

  // Update the shadow frame for one accepted request, queue any read byte
  function automatic void apply_request(input in_req_t r);
    int          x;
    int          y;
    int unsigned addr;
    int unsigned p;
    int unsigned size;
    logic [7:0]  px_byte;
    out_rsp_t    rsp;
    size = frame_bytes();
    x = $signed(r.pixel_x);
    y = $signed(r.pixel_y);
    case (r.req_type)
      REQ_DRAW: begin
        if (x >= 0 && y >= 0 && x < int'(vis_width()) && y < int'(vis_height())) begin
          addr = y * row_bytes() + x / 2;
          px_byte = shadow_store[addr];
          if (x % 2 == 1) px_byte = (px_byte & MASK_HI) | {4'h0, r.color};
          else px_byte = (px_byte & MASK_LO) | {r.color, 4'h0};
          shadow_store[addr] = px_byte;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < size && i < STORE_DEPTH; i++) shadow_store[i] = {r.color, r.color};
      end
      REQ_READ: begin
        p = next_byte;
        if (p >= size) p = 0;
        rsp.frame_byte = shadow_store[p];
        rsp.last_byte = (p + 1 >= size);
        expected_bytes.push_back(rsp);
        next_byte = rsp.last_byte ? 0 : p + 1;
      end
      default: ;
    endcase
  endfunction

  function automatic in_req_t make_req(input logic [1:0] kind, input int x, input int y,
                                       input logic [3:0] color);
    in_req_t r;
    r.req_type = kind;
    r.pixel_x = 16'(x);
    r.pixel_y = 16'(y);
    r.color = color;
    return r;
  endfunction

  // Mostly in-frame draws and reads, a few clears and unused codes
  function automatic in_req_t random_request(input int unsigned fw, input int unsigned fh);
    in_req_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.pixel_x = 16'($urandom);
    r.pixel_y = 16'($urandom);
    r.color = 4'($urandom);
    if (pick < 48) begin
      r.req_type = REQ_DRAW;
      if ($urandom_range(0, 4) != 0) begin
        r.pixel_x = 16'(int'($urandom_range(0, fw + 3)) - 2);
        r.pixel_y = 16'(int'($urandom_range(0, fh + 3)) - 2);
      end
    end else if (pick < 88) begin
      r.req_type = REQ_READ;
    end else if (pick < 92) begin
      r.req_type = REQ_CLEAR;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Present one request, hold it until accepted, then may idle before the next
  task automatic send_request(input in_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    apply_request(r);
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_requests();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    hold_requests();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Drain results, then give a trailing clear time to finish its sweep
  task automatic settle();
    wait_results();
    repeat (frame_bytes() + 16) @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w[8:0];
    @(posedge clk);
    width_reg = w[8:0];
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= {2'($urandom), h[6:0]};
    @(posedge clk);
    height_reg = h[6:0];
    cfg_we <= 1'b0;
  endtask

  // Nibble placement, bounds on both axes, the unused code, first reads
  task automatic test_point_draws();
    gaps_on = 1'b1;
    send_request(make_req(REQ_DRAW, 0, 0, 4'hF));
    send_request(make_req(REQ_DRAW, 1, 0, 4'h5));
    send_request(make_req(REQ_DRAW, 255, 63, 4'hA));
    send_request(make_req(REQ_DRAW, 256, 0, 4'h7));
    send_request(make_req(REQ_DRAW, -1, 0, 4'h7));
    send_request(make_req(REQ_DRAW, 0, 64, 4'h7));
    send_request(make_req(REQ_DRAW, -32768, 32767, 4'h7));
    send_request(make_req(REQ_DRAW, 32767, -32768, 4'h7));
    send_request(make_req(REQ_UNUSED, 0, 0, 4'h3));
    send_request(make_req(REQ_READ, 0, 0, 4'h0));
  endtask

  // Clear a tiny odd-width frame, overdraw it, read across the wrap
  task automatic test_clear_wrap();
    settle();
    set_frame(3, 2);
    send_request(make_req(REQ_CLEAR, 0, 0, 4'hA));
    send_request(make_req(REQ_DRAW, 2, 1, 4'hC));
    send_request(make_req(REQ_DRAW, 1, 0, 4'h0));
    repeat (4) send_request(make_req(REQ_READ, 0, 0, 4'h0));
  endtask

  // Shrink the frame under the read pointer so the next read restarts at zero
  task automatic test_pointer_restart();
    settle();
    set_frame(16, 4);
    repeat (5) send_request(make_req(REQ_READ, 0, 0, 4'h0));
    settle();
    set_frame(2, 2);
    repeat (2) send_request(make_req(REQ_READ, 0, 0, 4'h0));
  endtask

  // Zero and oversized geometry clamp to the supported range
  task automatic test_size_clamps();
    settle();
    set_frame(0, 0);
    send_request(make_req(REQ_DRAW, 0, 0, 4'h9));
    repeat (2) send_request(make_req(REQ_READ, 0, 0, 4'h0));
    settle();
    set_frame(511, 127);
    send_request(make_req(REQ_READ, 0, 0, 4'h0));
  endtask

  task automatic random_phase(input int unsigned w, input int unsigned h, input int n,
                              input bit gaps, input bit pause_mid);
    in_req_t     r;
    int unsigned fw;
    int unsigned fh;
    int          done;
    settle();
    set_frame(w, h);
    gaps_on = gaps;
    fw = vis_width();
    fh = vis_height();
    done = 0;
    while (done < n) begin
      // Hold off new requests until every pending read byte is back
      if (pause_mid && done == n / 2) begin
        wait_results();
        pause_mid = 1'b0;
      end
      r = random_request(fw, fh);
      send_request(r);
      if (r.req_type != REQ_UNUSED) done++;
    end
  endtask

  task automatic test_random_frames();
    int unsigned rw;
    int unsigned rh;
    rw = $urandom_range(1, 40);
    rh = $urandom_range(1, 8);
    random_phase(256, 64, 160, 1'b1, 1'b1);
    random_phase(1, 1, 40, 1'b0, 1'b0);
    random_phase(17, 5, 120, 1'b1, 1'b0);
    random_phase(511, 127, 100, 1'b0, 1'b0);
    random_phase(2, 1, 30, 1'b1, 1'b0);
    random_phase(rw, rh, 120, 1'b1, 1'b0);
    random_phase(255, 3, 120, 1'b0, 1'b0);
    random_phase(9, 64, 110, 1'b1, 1'b0);
  endtask

  // Accept read bytes, holding out_ready low at random before each while gaps are on
  initial begin : byte_sink
    int stall;
    forever begin
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Compare each accepted byte with the oldest prediction
  always @(posedge clk) begin : byte_check
    out_rsp_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected read byte: frame_byte %0h last_byte %0b",
               out_rsp.frame_byte, out_rsp.last_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_rsp.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %0h, actual %0h", want.frame_byte, out_rsp.frame_byte);
          errors++;
        end
        if (out_rsp.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte, out_rsp.last_byte);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : run
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_point_draws();
    test_clear_wrap();
    test_pointer_restart();
    test_size_clamps();
    test_random_frames();
    wait_results();
    repeat (32) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
